// ----- hw/rtl/lmc_pkg.sv -----
// lmc_pkg: shared types, constants and the window compare function for the
// local minimum counter. No dependencies.
`default_nettype none

package lmc_pkg;

	localparam int MAX_SIZE    = 256;
	localparam int VALUE_WIDTH = 16;
	localparam int ADDR_W      = $clog2(MAX_SIZE);
	localparam int CFG_W       = 9;
	localparam int COUNT_W     = 15;
	localparam int WIN_CELLS   = 9;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [CFG_W-1:0]   SIZE_MIN  = CFG_W'(2);
	localparam logic [CFG_W-1:0]   SIZE_TOP  = CFG_W'(MAX_SIZE);

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef val_t win_t [WIN_CELLS];

	// cell at window (wr, wc) is below every neighbor inside the window;
	// top_ok / left_ok admit the row above and the column to the left
	function automatic logic strict_min(input win_t w, input int wr, input int wc,
			input logic top_ok, input logic left_ok);
		logic ok;
		ok = 1'b1;
		for (int pr = 0; pr < 3; pr++) begin
			for (int pc = 0; pc < 3; pc++) begin
				if (!(pr == wr && pc == wc) && pr >= wr - 1 && pr <= wr + 1 &&
						pc >= wc - 1 && pc <= wc + 1 &&
						(pr != wr - 1 || top_ok) && (pc != wc - 1 || left_ok)) begin
					if (!(w[wr*3+wc] < w[pr*3+pc])) begin
						ok = 1'b0;
					end
				end
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lmc_ram.sv -----
// lmc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/local_minimum_counter_unit.sv -----
// local_minimum_counter_unit: counts strict 3x3 local minima of a streamed
// square matrix. Uses lmc_pkg and two lmc_ram line buffers.
// Result: the last element passes stage 1, then the result register raises m_tvalid.
// Throughput: one element per cycle unless a held result stalls stage 1; the line
// buffer read is issued on accept and the window update and compare run in the single
// stage after it. Reset: positions and count clear, matrix_size goes to 2, line
// buffers and window hold unknown data until written (never compared before that).
`default_nettype none

module local_minimum_counter_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: matrix_size
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lmc_pkg::CFG_W-1:0]   cfg_data,
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // [15:0] element_value
	// result stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [15:0]                      m_tdata    // [14:0] minima_count, [15] zero
);

	localparam int AW = lmc_pkg::ADDR_W;

	logic [lmc_pkg::CFG_W-1:0]   size_q;
	logic [lmc_pkg::CFG_W-1:0]   eff_size;
	logic [AW-1:0]               nm1;
	logic [AW-1:0]               col_q, row_q;
	logic                        valid_s1;
	lmc_pkg::val_t               val_s1;
	logic [AW-1:0]               col_s1, row_s1;
	lmc_pkg::win_t               win_q, win_n;
	lmc_pkg::val_t               older_rd, newer_rd;
	logic [lmc_pkg::COUNT_W-1:0] count_q;
	logic [lmc_pkg::COUNT_W-1:0] count_new;
	logic [lmc_pkg::COUNT_W:0]   count_sum;
	logic [2:0]                  hits;
	logic                        s_accept, cfg_accept, fire_s1, last_s1;
	logic                        c_any, r_any, c_last, r_last, top_ok, left_ok;
	logic                        out_valid_q;
	logic [lmc_pkg::COUNT_W-1:0] out_count_q;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	always_comb begin
		eff_size = size_q;
		if (size_q < lmc_pkg::SIZE_MIN) begin
			eff_size = lmc_pkg::SIZE_MIN;
		end else if (size_q > lmc_pkg::SIZE_TOP) begin
			eff_size = lmc_pkg::SIZE_TOP;
		end
	end
	assign nm1 = AW'(eff_size - lmc_pkg::CFG_W'(1));

	// stage 1 retires whenever the result register can take its output
	assign fire_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign s_accept = s_tvalid && s_tready;

	// read position, advanced on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= lmc_pkg::SIZE_MIN;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_accept) begin
			size_q <= cfg_data;
			col_q  <= '0;
			row_q  <= '0;
		end else if (s_accept) begin
			if (col_q == nm1) begin
				col_q <= '0;
				row_q <= (row_q == nm1) ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			val_s1 <= lmc_pkg::val_t'(s_tdata[lmc_pkg::VALUE_WIDTH-1:0]);
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	lmc_ram #(.WIDTH(lmc_pkg::VALUE_WIDTH), .DEPTH(lmc_pkg::MAX_SIZE)) u_older_ram (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (col_s1),
		.wdata (newer_rd),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	lmc_ram #(.WIDTH(lmc_pkg::VALUE_WIDTH), .DEPTH(lmc_pkg::MAX_SIZE)) u_newer_ram (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (col_s1),
		.wdata (val_s1),
		.re    (s_accept),
		.raddr (col_q),
		.rdata (newer_rd)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_n[k*3+0] = win_q[k*3+1];
			win_n[k*3+1] = win_q[k*3+2];
		end
		win_n[2] = older_rd;
		win_n[5] = newer_rd;
		win_n[8] = val_s1;
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			win_q <= win_n;
		end
	end

	assign c_any   = col_s1 != '0;
	assign r_any   = row_s1 != '0;
	assign c_last  = col_s1 == nm1;
	assign r_last  = row_s1 == nm1;
	assign top_ok  = row_s1[AW-1:1] != '0;
	assign left_ok = col_s1[AW-1:1] != '0;
	assign last_s1 = c_last && r_last;

	// up to four cells are settled by the arriving element
	always_comb begin
		hits = '0;
		if (r_any && c_any) begin
			hits = hits + 3'(lmc_pkg::strict_min(win_n, 1, 1, top_ok, left_ok));
		end
		if (r_any && c_last) begin
			hits = hits + 3'(lmc_pkg::strict_min(win_n, 1, 2, top_ok, 1'b1));
		end
		if (r_last && c_any) begin
			hits = hits + 3'(lmc_pkg::strict_min(win_n, 2, 1, 1'b1, left_ok));
		end
		if (r_last && c_last) begin
			hits = hits + 3'(lmc_pkg::strict_min(win_n, 2, 2, 1'b1, 1'b1));
		end
		count_sum = {1'b0, count_q} + (lmc_pkg::COUNT_W+1)'(hits);
		count_new = count_sum[lmc_pkg::COUNT_W] ? lmc_pkg::COUNT_MAX
			: count_sum[lmc_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_accept) begin
			count_q <= '0;
		end else if (fire_s1) begin
			count_q <= last_s1 ? '0 : count_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_count_q <= count_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_count_q};

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> m_tvalid)
		else $error("matrix end did not raise a result");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= nm1 && row_q <= nm1)
		else $error("position beyond matrix size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !fire_s1)
		else $error("stage retired while result register was blocked");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for local_minimum_counter_unit, the streamed
// strict 3x3 local-minimum counter. Depends on lmc_pkg and the unit's RTL only.
// Each finished matrix is recounted in full here and compared with the unit's result.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef lmc_pkg::val_t val_t;
	typedef logic [lmc_pkg::COUNT_W-1:0] count_t;
	typedef logic [lmc_pkg::CFG_W-1:0] size_t;

	// content styles for one generated matrix
	typedef enum int {FILL_FULL, FILL_TIES, FILL_CHECKER, FILL_EXTREME} fill_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	size_t       cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [15:0] element_value
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [14:0] minima_count, [15] zero

	local_minimum_counter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// copy of the matrix being streamed, recounted when its last element lands
	val_t   grid [lmc_pkg::MAX_SIZE][lmc_pkg::MAX_SIZE];
	int     side;
	int     next_row;
	int     next_col;
	count_t expected_counts [$];

	bit     gaps_on;
	int     elements_sent;
	int     matrices_done;
	int     largest_side;
	int     largest_count;
	int     mismatches;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// receiver side stalls
	always @(negedge clk) begin
		m_tready <= !gaps_on || ($urandom_range(99) >= 16);
	end

	function automatic count_t count_strict_minima(input int n);
		int total;
		int rr;
		int cc;
		bit lowest;
		total = 0;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				lowest = 1'b1;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && rr < n && cc >= 0 && cc < n) begin
							if (!(grid[r][c] < grid[rr][cc])) begin
								lowest = 1'b0;
							end
						end
					end
				end
				if (lowest) begin
					total++;
				end
			end
		end
		if (total > int'(lmc_pkg::COUNT_MAX)) begin
			total = int'(lmc_pkg::COUNT_MAX);
		end
		return count_t'(total);
	endfunction

	// one accepted element moves the raster position; the last one closes the matrix
	function automatic void record_element(input val_t v);
		count_t cnt;
		grid[next_row][next_col] = v;
		elements_sent++;
		if (next_col + 1 < side) begin
			next_col++;
		end else begin
			next_col = 0;
			if (next_row + 1 < side) begin
				next_row++;
			end else begin
				next_row = 0;
				cnt = count_strict_minima(side);
				expected_counts.push_back(cnt);
				matrices_done++;
				if (side > largest_side) begin
					largest_side = side;
				end
				if (int'(cnt) > largest_count) begin
					largest_count = int'(cnt);
				end
			end
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %h with no matrix outstanding", $time, m_tdata);
				end
			end else if (m_tdata !== {1'b0, expected_counts[0]}) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: minima_count expected %0d got %0d (tdata %h)", $time,
						expected_counts[0], m_tdata[lmc_pkg::COUNT_W-1:0], m_tdata);
				end
				void'(expected_counts.pop_front());
			end else begin
				void'(expected_counts.pop_front());
			end
		end
	end

	task automatic send_element(input val_t v);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		record_element(v);
	endtask

	// drop the stream and wait until every count is back and the pipe has drained
	task automatic settle();
		@(negedge clk);
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input size_t v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		side     = (v < lmc_pkg::SIZE_MIN) ? int'(lmc_pkg::SIZE_MIN)
			: (v > lmc_pkg::SIZE_TOP) ? lmc_pkg::MAX_SIZE : int'(v);
		next_row = 0;
		next_col = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic val_t element_for(input fill_t fill, input int r, input int c,
			input int phase);
		bit low_cell;
		low_cell = ((r + phase) % 2 == 0) && ((c + (phase >> 1)) % 2 == 0);
		case (fill)
			FILL_TIES: begin
				return val_t'($urandom_range(3)) - val_t'(1);
			end
			FILL_CHECKER: begin
				return low_cell ? val_t'(-int'($urandom_range(32768, 1)))
					: val_t'($urandom_range(32767));
			end
			FILL_EXTREME: begin
				case ($urandom_range(3))
					0: return val_t'(16'h8000);
					1: return val_t'(16'h7fff);
					2: return val_t'(0);
					default: return val_t'(-1);
				endcase
			end
			default: begin
				return val_t'($urandom);
			end
		endcase
	endfunction

	task automatic send_matrix(input fill_t fill, input int count);
		int phase;
		phase = $urandom_range(3);
		for (int k = 0; k < count; k++) begin
			send_element(element_for(fill, next_row, next_col, phase));
		end
	endtask

	// size 2 straight out of reset, extreme values in the corners
	task automatic test_reset_size();
		send_element(val_t'(16'h8000));
		send_element(val_t'(16'h7fff));
		send_element(val_t'(16'h7fff));
		send_element(val_t'(16'h7fff));
	endtask

	// written sizes of zero and one act as two
	task automatic test_low_sizes();
		write_size(size_t'(0));
		send_element(val_t'(-1));
		send_element(val_t'(0));
		send_element(val_t'(0));
		send_element(val_t'(0));
		write_size(size_t'(1));
		send_element(val_t'(5));
		send_element(val_t'(5));
		send_element(val_t'(5));
		send_element(val_t'(5));
	endtask

	// 3x3 whose only minimum sits in a corner, a tie on the edge and both extremes
	task automatic test_interior();
		val_t vals [9];
		vals = '{val_t'(7), val_t'(16'h7fff), val_t'(7), val_t'(3), val_t'(-5), val_t'(3),
			val_t'(7), val_t'(7), val_t'(16'h8000)};
		write_size(size_t'(3));
		foreach (vals[k]) begin
			send_element(vals[k]);
		end
	endtask

	// a size write after a partial matrix starts a fresh one
	task automatic test_restart();
		write_size(size_t'(3));
		send_element(val_t'(-9));
		send_element(val_t'(4));
		send_element(val_t'(-9));
		write_size(size_t'(2));
		send_element(val_t'(3));
		send_element(val_t'(2));
		send_element(val_t'(1));
		send_element(val_t'(0));
	endtask

	task automatic test_random_matrices();
		int start;
		int n;
		fill_t fill;
		start = elements_sent;
		while (elements_sent - start < 850) begin
			// one long stretch with no stalls on either side
			gaps_on = !(elements_sent - start >= 300 && elements_sent - start < 650);
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: write_size(size_t'($urandom_range(1)));
					1, 2: write_size(size_t'($urandom_range(16, 2)));
					default: write_size(size_t'($urandom_range(6, 2)));
				endcase
			end
			n = side * side;
			fill = fill_t'($urandom_range(3));
			if ($urandom_range(11) == 0) begin
				// broken matrix, abandoned by a size write
				send_matrix(fill, $urandom_range(n - 1, 1));
				write_size(size_t'($urandom_range(5, 2)));
			end else begin
				send_matrix(fill, n);
			end
		end
		gaps_on = 1'b1;
	endtask

	// largest size: a full row and the start of the next at 256, then an oversize
	// write that clamps to 256, both abandoned; a small matrix then checks the restart
	task automatic test_largest_size();
		write_size(size_t'(lmc_pkg::MAX_SIZE));
		send_matrix(FILL_CHECKER, lmc_pkg::MAX_SIZE + 40);
		write_size(size_t'(9'h1ff));
		send_matrix(FILL_FULL, lmc_pkg::MAX_SIZE + 8);
		write_size(size_t'(2));
		send_matrix(FILL_TIES, 4);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		gaps_on   = 1'b1;
		side      = int'(lmc_pkg::SIZE_MIN);
		next_row  = 0;
		next_col  = 0;
		elements_sent = 0;
		matrices_done = 0;
		largest_side  = 0;
		largest_count = 0;
		mismatches    = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_size();
		test_low_sizes();
		test_interior();
		test_restart();
		test_random_matrices();
		test_largest_size();

		settle();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d elements streamed, %0d matrices counted", elements_sent,
			matrices_done);
		$display("tb_top: sizes up to %0d, highest count %0d, %0d mismatches", largest_side,
			largest_count, mismatches);
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
